@@ sv/bbal_pkg.sv @@
package bbal_pkg;

  localparam int DATA_W    = 48;
  localparam int BASE_W    = 32;
  localparam int LC_W      = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0] BASE_RESET = 32'd256;
  localparam logic [LC_W-1:0]   LC_RESET   = 4'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_BADALIGN = 2'd2;
  localparam logic [1:0] ST_BADFREE  = 2'd3;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_FREE  = 2'd1;
  localparam logic [1:0] MARK_SPLIT = 2'd2;
  localparam logic [1:0] MARK_TAKEN = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

@@ sv/bbal_ram.sv @@
module bbal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rd_r <= mem_r[addr];
  end

  assign rdata = rd_r;

endmodule

@@ sv/bbal_div.sv @@
module bbal_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bbal_pkg::DATA_W-1:0] dividend,
  input  logic [bbal_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [bbal_pkg::DATA_W-1:0] quo,
  output logic [bbal_pkg::DATA_W-1:0] rem
);

  localparam int W  = bbal_pkg::DATA_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo_r, rem_r, div_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [W:0]    trial;
  logic          fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        quo_r <= dividend;
        div_r <= divisor;
        cnt_r <= CW'(W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? W'(trial - {1'b0, div_r}) : W'(trial);
        quo_r <= {quo_r[W-2:0], fits};
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ sv/buddy_block_allocator_top.sv @@
// Binary buddy allocator over a region of 2^(levels-1) base blocks.
// A request is taken when start is high and busy is low. in_operation picks
// allocate or free; the size, alignment and offset fields are sampled then.
// Exactly one result follows: out_valid is high for one cycle with out_status
// and out_granted_offset. The receiver cannot stall, so results are never held.
// A request first finds the size level, then runs the shared bit-serial
// divider (alignment check or block index of a free), then the free-list
// walk. An allocate finds a nonempty list, splits one level at a time and
// takes the block; a free merges upward while the buddy is free, scanning
// its list for the buddy, and ends with the final push. Requests without
// splits or merges are quickest; a free whose buddies sit deep in long lists
// takes longest. The node and mark memories are single-port, so every list
// update is a read followed by a write.
// Reset and every write to the base size or level count register start a
// clearing pass over both memories, during which busy is high; the region then holds
// one free top block. Configuration writes are always accepted (cfg_ready is
// high) and are meant to be issued only while no request is outstanding.
module buddy_block_allocator_top #(
  parameter int MAX_LEVELS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [bbal_pkg::DATA_W-1:0]    in_request_bytes,
  input  logic [bbal_pkg::DATA_W-1:0]    in_alignment_bytes,
  input  logic [bbal_pkg::DATA_W-1:0]    in_free_offset,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [bbal_pkg::DATA_W-1:0]    out_granted_offset,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbal_pkg::BASE_W-1:0]    cfg_data
);

  localparam int DW   = bbal_pkg::DATA_W;
  localparam int BASW = bbal_pkg::BASE_W;
  localparam int NW   = MAX_LEVELS;
  localparam int NODE_COUNT = (1 << MAX_LEVELS) - 1;
  localparam int LVW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int BW   = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
  localparam int NDW  = NW + BW;
  localparam logic [NW-1:0] LINK_NONE = NW'(NODE_COUNT);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_SIZE   = 5'd2;
  localparam logic [4:0] S_DIVW   = 5'd3;
  localparam logic [4:0] S_FIND   = 5'd4;
  localparam logic [4:0] S_POPA   = 5'd5;
  localparam logic [4:0] S_POPB   = 5'd6;
  localparam logic [4:0] S_SPM0   = 5'd7;
  localparam logic [4:0] S_SPM1   = 5'd8;
  localparam logic [4:0] S_SPM2   = 5'd9;
  localparam logic [4:0] S_PUSHA  = 5'd10;
  localparam logic [4:0] S_PUSHB  = 5'd11;
  localparam logic [4:0] S_PRET   = 5'd12;
  localparam logic [4:0] S_TAKE   = 5'd13;
  localparam logic [4:0] S_OFFS   = 5'd14;
  localparam logic [4:0] S_FCHK   = 5'd15;
  localparam logic [4:0] S_FMARK  = 5'd16;
  localparam logic [4:0] S_MGT    = 5'd17;
  localparam logic [4:0] S_MGE    = 5'd18;
  localparam logic [4:0] S_RMA    = 5'd19;
  localparam logic [4:0] S_RMB    = 5'd20;
  localparam logic [4:0] S_RMLINK = 5'd21;
  localparam logic [4:0] S_RMGIVE = 5'd22;
  localparam logic [4:0] S_MGN0   = 5'd23;
  localparam logic [4:0] S_MGN1   = 5'd24;
  localparam logic [4:0] S_MGUP   = 5'd25;

  // Where a list push returns to.
  localparam logic [1:0] R_SPLIT_HI = 2'd0;
  localparam logic [1:0] R_SPLIT_LO = 2'd1;
  localparam logic [1:0] R_FREE     = 2'd2;

  // Effective top level index from the level count register.
  function automatic logic [LVW-1:0] eff_top(input logic [bbal_pkg::LC_W-1:0] lc);
    logic [LVW-1:0] t;
    if (lc == '0) begin
      t = '0;
    end else if (int'(lc) > MAX_LEVELS) begin
      t = LVW'(MAX_LEVELS - 1);
    end else begin
      t = LVW'(int'(lc) - 1);
    end
    return t;
  endfunction

  // Mark memory address of a block: levels are packed bottom up, so level l
  // starts at 2^L - 2^(L-l) with L = top + 1.
  function automatic logic [NW-1:0] slot_of(input logic [LVW-1:0] t,
                                            input logic [LVW-1:0] l,
                                            input logic [BW-1:0] b);
    logic [NW:0] hi;
    logic [NW:0] lo;
    hi = (NW+1)'(1) << (int'(t) + 1);
    lo = (NW+1)'(1) << (int'(t) + 1 - int'(l));
    return NW'(hi - lo + (NW+1)'(b));
  endfunction

  logic [4:0]             state_r;
  logic [BASW-1:0]        base_r;
  logic [bbal_pkg::LC_W-1:0] lc_r;
  logic                   op_r;
  logic [DW-1:0]          req_r, aln_r, foff_r;
  logic [LVW-1:0]         lvl_r, s_r, plv_r;
  logic [BW-1:0]          blk_r, pblk_r, prev_blk_r;
  logic [NW-1:0]          n_r, prev_r, link_r, spare_r, clr_r;
  logic [NW-1:0]          head_r [MAX_LEVELS];
  logic [1:0]             ret_r;
  logic [BASW+BW-1:0]     prod_r;
  logic                   div_start_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [DW-1:0]          out_offset_r;

  logic [LVW-1:0]         top;
  logic [BASW-1:0]        base_eff;
  logic [DW-1:0]          bsize;
  logic                   size_fits;
  logic                   div_done;
  logic [DW-1:0]          div_quo, div_rem;
  logic [DW-1:0]          div_a, div_b;

  logic                   mark_we;
  logic [NW-1:0]          mark_addr;
  logic [1:0]             mark_wdata, mark_rd;
  logic                   node_we;
  logic [NW-1:0]          node_addr;
  logic [NDW-1:0]         node_wdata, node_rd;
  logic [NW-1:0]          rd_next;
  logic [BW-1:0]          rd_blk;

  logic                   cfg_wr;
  logic [bbal_pkg::LC_W-1:0] lc_new;

  assign top       = eff_top(lc_r);
  assign base_eff  = (base_r == '0) ? BASW'(1) : base_r;
  assign bsize     = DW'(base_eff) << lvl_r;
  assign size_fits = ((64'(base_eff)) << lvl_r) >= 64'(req_r);
  assign rd_next   = node_rd[NDW-1:BW];
  assign rd_blk    = node_rd[BW-1:0];

  // The shared divider checks alignment (block size by alignment) for an
  // allocate and finds the block index (offset by block size) for a free.
  assign div_a = (op_r == bbal_pkg::OP_FREE) ? foff_r : bsize;
  assign div_b = (op_r == bbal_pkg::OP_FREE) ? bsize : aln_r;

  bbal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  bbal_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .addr  (mark_addr),
    .wdata (mark_wdata),
    .rdata (mark_rd)
  );

  bbal_ram #(.WIDTH(NDW), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .addr  (node_addr),
    .wdata (node_wdata),
    .rdata (node_rd)
  );

  // Memory port control. Every read is issued one state ahead of the state
  // that consumes its data, and no read follows a write to the same entry in
  // the same cycle.
  always_comb begin
    mark_we    = 1'b0;
    mark_addr  = slot_of(top, lvl_r, blk_r);
    mark_wdata = bbal_pkg::MARK_NONE;
    node_we    = 1'b0;
    node_addr  = n_r;
    node_wdata = {spare_r, blk_r};
    case (state_r)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_addr  = clr_r;
        mark_wdata = (clr_r == slot_of(top, top, '0)) ? bbal_pkg::MARK_FREE
                                                      : bbal_pkg::MARK_NONE;
        node_we    = 1'b1;
        node_addr  = clr_r;
        node_wdata = {((clr_r == '0) ? LINK_NONE : NW'(clr_r + 1'b1)), BW'(0)};
      end
      S_POPA: begin
        node_addr = head_r[s_r];
      end
      S_POPB: begin
        node_we    = 1'b1;
        node_wdata = {spare_r, rd_blk};
      end
      S_SPM0: begin
        mark_we    = 1'b1;
        mark_addr  = slot_of(top, s_r, blk_r);
        mark_wdata = bbal_pkg::MARK_SPLIT;
      end
      S_SPM1: begin
        mark_we    = 1'b1;
        mark_addr  = slot_of(top, s_r - 1'b1, BW'({blk_r, 1'b0}));
        mark_wdata = bbal_pkg::MARK_FREE;
      end
      S_SPM2: begin
        mark_we    = 1'b1;
        mark_addr  = slot_of(top, s_r - 1'b1, BW'({blk_r, 1'b1}));
        mark_wdata = bbal_pkg::MARK_FREE;
      end
      S_PUSHA: begin
        node_addr = spare_r;
      end
      S_PUSHB: begin
        node_we    = 1'b1;
        node_wdata = {head_r[plv_r], pblk_r};
      end
      S_TAKE: begin
        mark_we    = 1'b1;
        mark_wdata = bbal_pkg::MARK_TAKEN;
      end
      S_FCHK: begin
        mark_addr = slot_of(top, lvl_r, div_quo[BW-1:0]);
      end
      S_FMARK: begin
        mark_we    = (mark_rd == bbal_pkg::MARK_TAKEN);
        mark_wdata = bbal_pkg::MARK_FREE;
      end
      S_MGT: begin
        mark_addr = slot_of(top, lvl_r, blk_r ^ BW'(1));
      end
      S_RMLINK: begin
        node_we    = 1'b1;
        node_addr  = prev_r;
        node_wdata = {link_r, prev_blk_r};
      end
      S_RMGIVE: begin
        node_we    = 1'b1;
        node_wdata = {spare_r, blk_r ^ BW'(1)};
      end
      S_MGN0: begin
        mark_we    = 1'b1;
        mark_wdata = bbal_pkg::MARK_NONE;
      end
      S_MGN1: begin
        mark_we    = 1'b1;
        mark_addr  = slot_of(top, lvl_r, blk_r ^ BW'(1));
        mark_wdata = bbal_pkg::MARK_NONE;
      end
      S_MGUP: begin
        mark_we    = 1'b1;
        mark_wdata = bbal_pkg::MARK_FREE;
      end
      default: begin
      end
    endcase
  end

  assign cfg_wr = cfg_valid && cfg_ready;
  assign lc_new = (cfg_index == bbal_pkg::CFG_LEVEL_COUNT) ? cfg_data[bbal_pkg::LC_W-1:0]
                                                          : lc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      base_r      <= bbal_pkg::BASE_RESET;
      lc_r        <= bbal_pkg::LC_RESET;
      spare_r     <= NW'(1);
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= (LVW'(i) == eff_top(bbal_pkg::LC_RESET)) ? NW'(0) : LINK_NONE;
      end
    end else if (cfg_wr && (cfg_index == bbal_pkg::CFG_BASE_BYTES ||
                            cfg_index == bbal_pkg::CFG_LEVEL_COUNT)) begin
      // A write to either register rebuilds the store around the new geometry.
      if (cfg_index == bbal_pkg::CFG_BASE_BYTES) begin
        base_r <= cfg_data;
      end else begin
        lc_r <= lc_new;
      end
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      spare_r     <= NW'(1);
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= (LVW'(i) == eff_top(lc_new)) ? NW'(0) : LINK_NONE;
      end
    end else begin
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_operation;
            req_r   <= in_request_bytes;
            aln_r   <= in_alignment_bytes;
            foff_r  <= in_free_offset;
            lvl_r   <= '0;
            state_r <= S_SIZE;
          end
        end
        S_CLEAR: begin
          if (clr_r == NW'(NODE_COUNT - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_SIZE: begin
          // Smallest level whose block covers the request.
          if (size_fits) begin
            if (op_r == bbal_pkg::OP_ALLOC && aln_r == '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bbal_pkg::ST_BADALIGN;
              out_offset_r <= '0;
              state_r      <= S_IDLE;
            end else begin
              div_start_r <= 1'b1;
              state_r     <= S_DIVW;
            end
          end else if (lvl_r == top) begin
            out_valid_r  <= 1'b1;
            out_status_r <= (op_r == bbal_pkg::OP_FREE) ? bbal_pkg::ST_BADFREE
                                                        : bbal_pkg::ST_NOMEM;
            out_offset_r <= '0;
            state_r      <= S_IDLE;
          end else begin
            lvl_r <= lvl_r + 1'b1;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (op_r == bbal_pkg::OP_FREE) begin
              state_r <= S_FCHK;
            end else if (div_rem != '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bbal_pkg::ST_BADALIGN;
              out_offset_r <= '0;
              state_r      <= S_IDLE;
            end else begin
              s_r     <= lvl_r;
              state_r <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (head_r[s_r] != LINK_NONE) begin
            state_r <= S_POPA;
          end else if (s_r == top) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bbal_pkg::ST_NOMEM;
            out_offset_r <= '0;
            state_r      <= S_IDLE;
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        S_POPA: begin
          if (head_r[s_r] == LINK_NONE) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bbal_pkg::ST_NOMEM;
            out_offset_r <= '0;
            state_r      <= S_IDLE;
          end else begin
            n_r     <= head_r[s_r];
            state_r <= S_POPB;
          end
        end
        S_POPB: begin
          blk_r       <= rd_blk;
          head_r[s_r] <= rd_next;
          spare_r     <= n_r;
          state_r     <= (s_r != lvl_r) ? S_SPM0 : S_TAKE;
        end
        S_SPM0: begin
          state_r <= S_SPM1;
        end
        S_SPM1: begin
          state_r <= S_SPM2;
        end
        S_SPM2: begin
          // Upper half goes in first so that the lower half ends at the head.
          plv_r   <= s_r - 1'b1;
          pblk_r  <= BW'({blk_r, 1'b1});
          ret_r   <= R_SPLIT_HI;
          state_r <= S_PUSHA;
        end
        S_PUSHA: begin
          if (spare_r == LINK_NONE) begin
            state_r <= S_PRET;
          end else begin
            n_r     <= spare_r;
            state_r <= S_PUSHB;
          end
        end
        S_PUSHB: begin
          spare_r       <= rd_next;
          head_r[plv_r] <= n_r;
          state_r       <= S_PRET;
        end
        S_PRET: begin
          case (ret_r)
            R_SPLIT_HI: begin
              pblk_r  <= BW'({blk_r, 1'b0});
              ret_r   <= R_SPLIT_LO;
              state_r <= S_PUSHA;
            end
            R_SPLIT_LO: begin
              s_r     <= s_r - 1'b1;
              state_r <= S_POPA;
            end
            default: begin
              out_valid_r  <= 1'b1;
              out_status_r <= bbal_pkg::ST_OK;
              out_offset_r <= '0;
              state_r      <= S_IDLE;
            end
          endcase
        end
        S_TAKE: begin
          prod_r  <= (BASW+BW)'(blk_r) * (BASW+BW)'(base_eff);
          state_r <= S_OFFS;
        end
        S_OFFS: begin
          out_valid_r  <= 1'b1;
          out_status_r <= bbal_pkg::ST_OK;
          out_offset_r <= DW'((64'(prod_r)) << lvl_r);
          state_r      <= S_IDLE;
        end
        S_FCHK: begin
          if ((div_quo >> (top - lvl_r)) != '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bbal_pkg::ST_BADFREE;
            out_offset_r <= '0;
            state_r      <= S_IDLE;
          end else begin
            blk_r   <= div_quo[BW-1:0];
            state_r <= S_FMARK;
          end
        end
        S_FMARK: begin
          if (mark_rd != bbal_pkg::MARK_TAKEN) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bbal_pkg::ST_BADFREE;
            out_offset_r <= '0;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_MGT;
          end
        end
        S_MGT: begin
          if (lvl_r < top) begin
            state_r <= S_MGE;
          end else begin
            plv_r   <= lvl_r;
            pblk_r  <= blk_r;
            ret_r   <= R_FREE;
            state_r <= S_PUSHA;
          end
        end
        S_MGE: begin
          if (mark_rd == bbal_pkg::MARK_FREE) begin
            prev_r  <= LINK_NONE;
            n_r     <= head_r[lvl_r];
            state_r <= S_RMA;
          end else begin
            plv_r   <= lvl_r;
            pblk_r  <= blk_r;
            ret_r   <= R_FREE;
            state_r <= S_PUSHA;
          end
        end
        S_RMA: begin
          state_r <= (n_r == LINK_NONE) ? S_MGN0 : S_RMB;
        end
        S_RMB: begin
          if (rd_blk == (blk_r ^ BW'(1))) begin
            link_r <= rd_next;
            if (prev_r == LINK_NONE) begin
              head_r[lvl_r] <= rd_next;
              state_r       <= S_RMGIVE;
            end else begin
              state_r <= S_RMLINK;
            end
          end else begin
            prev_r     <= n_r;
            prev_blk_r <= rd_blk;
            n_r        <= rd_next;
            state_r    <= S_RMA;
          end
        end
        S_RMLINK: begin
          state_r <= S_RMGIVE;
        end
        S_RMGIVE: begin
          spare_r <= n_r;
          state_r <= S_MGN0;
        end
        S_MGN0: begin
          state_r <= S_MGN1;
        end
        S_MGN1: begin
          blk_r   <= blk_r >> 1;
          lvl_r   <= lvl_r + 1'b1;
          state_r <= S_MGUP;
        end
        S_MGUP: begin
          state_r <= S_MGT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_offset_r;

  // A result is only shown once the sequencer has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  // No request can finish in the cycle right after it was taken.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_valid) |=> !out_valid_r)
    else $error("result one cycle after request");

  // Failed requests never report an offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bbal_pkg::ST_OK) |-> (out_offset_r == '0))
    else $error("offset on failed request");

  // The divider is never restarted while a result is being waited for.
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> ($past(state_r) == S_SIZE))
    else $error("divider started outside size phase");

endmodule
